/* hdl/sga_pkg.sv */
// ----------------------------------------------------------------------------
// sga_pkg
// Shared types and constants of the sorted group aggregator: request and
// response payloads, configuration bundle, push control and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package sga_pkg;

   // default parameter values
   localparam int DEF_MAX_VALUE_BYTES = 8;
   localparam int DEF_KEY_WIDTH       = 64;

   // fixed field widths
   localparam int KEY_BITS   = 64;
   localparam int VALUE_BITS = 64;
   localparam int COUNT_BITS = 32;
   localparam int BYTES_BITS = 4;

   // configuration port
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VALUE_SIGNED = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VALUE_BYTES  = 1'b1;
   localparam logic [BYTES_BITS-1:0]     RESET_VALUE_BYTES = 4'd4;

   // result queue depth, room for two pushes behind a stalled head
   localparam int RSP_DEPTH     = 4;
   localparam int RSP_PTR_BITS  = 2;
   localparam int RSP_CNT_BITS  = 3;

   typedef struct packed {
      logic [KEY_BITS-1:0]   group_key;
      logic [VALUE_BITS-1:0] value;
      logic                  end_of_input;
   } req_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]   result_key;
      logic [COUNT_BITS-1:0] record_count;
      logic [VALUE_BITS-1:0] value_sum;
      logic [VALUE_BITS-1:0] value_min;
      logic [VALUE_BITS-1:0] value_max;
      logic                  final_group;
   } rsp_type;

   typedef struct packed {
      logic                  value_signed;
      logic [BYTES_BITS-1:0] value_bytes;
   } cfg_type;

   // push_second is only set together with push_first
   typedef struct packed {
      logic push_first;
      logic push_second;
   } push_ctl_type;

endpackage

`default_nettype wire

/* hdl/sorted_group_aggregator.sv */
// ----------------------------------------------------------------------------
// sorted_group_aggregator
// Streaming group-by over a key-sorted record stream with count, sum, min
// and max per group and a configurable value width and signedness.
// A closed group's result goes from the input register into the 4-entry result queue.
// Throughput: one record per cycle while the queue has room for two; a record
// closing two groups queues two results, drained one per cycle under rsp_ready.
// Reset (synchronous): no group open, queue empty, value_signed 0,
// value_bytes 4.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_group_aggregator #(
   parameter int MAX_VALUE_BYTES = sga_pkg::DEF_MAX_VALUE_BYTES,
   parameter int KEY_WIDTH       = sga_pkg::DEF_KEY_WIDTH
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  sga_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output sga_pkg::rsp_type                    rsp_data,
   input  wire                                 csr_write_en,
   input  wire [sga_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire [sga_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   sga_pkg::cfg_type      cfg_ff;
   sga_pkg::cfg_type      cfg_in;
   logic                  item_valid;
   sga_pkg::req_type      item_data;
   logic                  item_take;
   logic                  room;
   sga_pkg::push_ctl_type push_ctl;
   sga_pkg::rsp_type      rsp_first;
   sga_pkg::rsp_type      rsp_second;

   // configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            sga_pkg::CSR_VALUE_SIGNED: cfg_in.value_signed = csr_wdata[0];
            sga_pkg::CSR_VALUE_BYTES:  cfg_in.value_bytes  = csr_wdata;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.value_signed <= 1'b0;
         cfg_ff.value_bytes  <= sga_pkg::RESET_VALUE_BYTES;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input register
   sga_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .item_valid (item_valid),
      .item_data  (item_data),
      .item_take  (item_take)
   );

   // group state and update
   sga_group_core #(
      .MAX_VALUE_BYTES (MAX_VALUE_BYTES),
      .KEY_WIDTH       (KEY_WIDTH)
   ) u_group_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (item_valid),
      .item_data  (item_data),
      .room       (room),
      .item_take  (item_take),
      .push_ctl   (push_ctl),
      .rsp_first  (rsp_first),
      .rsp_second (rsp_second)
   );

   // result queue
   sga_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_ctl   (push_ctl),
      .rsp_first  (rsp_first),
      .rsp_second (rsp_second),
      .room       (room),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

/* hdl/sga_in_stage.sv */
// ----------------------------------------------------------------------------
// sga_in_stage
// Input register of the aggregator. Holds one request and takes the next in
// the same cycle that the held one is consumed.
// ----------------------------------------------------------------------------
`default_nettype none

module sga_in_stage (
   input  wire             clock,
   input  wire             reset,
   input  wire             req_valid,
   output logic            req_ready,
   input  sga_pkg::req_type req_data,
   output logic            item_valid,
   output sga_pkg::req_type item_data,
   input  wire             item_take
);

   logic             valid_ff;
   logic             valid_in;
   sga_pkg::req_type data_ff;

   // ready when empty or when the held item leaves this cycle
   assign req_ready  = !valid_ff || item_take;
   assign item_valid = valid_ff;
   assign item_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (item_take) begin
         valid_in = 1'b0;
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff <= req_data;
      end
   end

endmodule

`default_nettype wire

/* hdl/sga_group_core.sv */
// ----------------------------------------------------------------------------
// sga_group_core
// Running group state and the per-record update: key compare, count, wrapping
// sum and width-aware min and max. Produces up to two results per record.
// ----------------------------------------------------------------------------
`default_nettype none

module sga_group_core #(
   parameter int MAX_VALUE_BYTES = sga_pkg::DEF_MAX_VALUE_BYTES,
   parameter int KEY_WIDTH       = sga_pkg::DEF_KEY_WIDTH
) (
   input  wire                   clock,
   input  wire                   reset,
   input  sga_pkg::cfg_type      cfg,
   input  wire                   item_valid,
   input  sga_pkg::req_type      item_data,
   input  wire                   room,
   output logic                  item_take,
   output sga_pkg::push_ctl_type push_ctl,
   output sga_pkg::rsp_type      rsp_first,
   output sga_pkg::rsp_type      rsp_second
);

   localparam int VALUE_W = 8 * MAX_VALUE_BYTES;

   logic                           open_ff;
   logic                           open_in;
   logic [KEY_WIDTH-1:0]           key_ff;
   logic [KEY_WIDTH-1:0]           key_in;
   logic [sga_pkg::COUNT_BITS-1:0] count_ff;
   logic [sga_pkg::COUNT_BITS-1:0] count_in;
   logic [sga_pkg::VALUE_BITS-1:0] sum_ff;
   logic [sga_pkg::VALUE_BITS-1:0] sum_in;
   logic [VALUE_W-1:0]             min_ff;
   logic [VALUE_W-1:0]             min_in;
   logic [VALUE_W-1:0]             max_ff;
   logic [VALUE_W-1:0]             max_in;

   logic [sga_pkg::BYTES_BITS-1:0] eff_bytes;
   logic [sga_pkg::VALUE_BITS-1:0] width_mask;
   logic [sga_pkg::VALUE_BITS-1:0] sign_mask;
   logic [sga_pkg::VALUE_BITS-1:0] bias;
   logic [sga_pkg::VALUE_BITS-1:0] val_m;
   logic [sga_pkg::VALUE_BITS-1:0] val_ext;
   logic [sga_pkg::VALUE_BITS-1:0] min_old;
   logic [sga_pkg::VALUE_BITS-1:0] max_old;
   logic [KEY_WIDTH-1:0]           rec_key;
   logic                           key_change;
   logic                           emit_prev;
   logic                           fresh;
   logic                           eoi;
   sga_pkg::rsp_type               prev_rsp;
   sga_pkg::rsp_type               final_rsp;

   // a < b after masking and biasing the sign bit
   function automatic logic less_than(
      input logic [sga_pkg::VALUE_BITS-1:0] a,
      input logic [sga_pkg::VALUE_BITS-1:0] b,
      input logic [sga_pkg::VALUE_BITS-1:0] mask,
      input logic [sga_pkg::VALUE_BITS-1:0] bs
   );
      return ((a & mask) ^ bs) < ((b & mask) ^ bs);
   endfunction

   // clamp configured width to 1..MAX_VALUE_BYTES
   always_comb begin
      eff_bytes = cfg.value_bytes;
      if (eff_bytes == '0) begin
         eff_bytes = sga_pkg::BYTES_BITS'(1);
      end
      if (eff_bytes > sga_pkg::BYTES_BITS'(MAX_VALUE_BYTES)) begin
         eff_bytes = sga_pkg::BYTES_BITS'(MAX_VALUE_BYTES);
      end
   end

   // byte masks for the value width and its sign bit
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         width_mask[8*i +: 8] = (sga_pkg::BYTES_BITS'(i) < eff_bytes) ? 8'hff : 8'h00;
         sign_mask[8*i +: 8]  = (sga_pkg::BYTES_BITS'(i + 1) == eff_bytes) ? 8'h80 : 8'h00;
      end
   end

   // record operands
   assign bias      = cfg.value_signed ? sign_mask : '0;
   assign val_m     = item_data.value & width_mask;
   assign val_ext   = (cfg.value_signed && ((val_m & sign_mask) != '0)) ?
                      (val_m | ~width_mask) : val_m;
   assign rec_key   = item_data.group_key[KEY_WIDTH-1:0];
   assign eoi       = item_data.end_of_input;
   assign min_old   = sga_pkg::VALUE_BITS'(min_ff);
   assign max_old   = sga_pkg::VALUE_BITS'(max_ff);
   assign key_change = (rec_key != key_ff);
   assign emit_prev = open_ff && key_change;
   assign fresh     = !open_ff || key_change;

   // group update
   always_comb begin
      if (fresh) begin
         count_in = sga_pkg::COUNT_BITS'(1);
         sum_in   = val_ext;
         min_in   = val_m[VALUE_W-1:0];
         max_in   = val_m[VALUE_W-1:0];
      end else begin
         count_in = count_ff + sga_pkg::COUNT_BITS'(1);
         sum_in   = sum_ff + val_ext;
         min_in   = less_than(val_m, min_old, width_mask, bias) ?
                    val_m[VALUE_W-1:0] : min_ff;
         max_in   = less_than(max_old, val_m, width_mask, bias) ?
                    val_m[VALUE_W-1:0] : max_ff;
      end
      key_in  = rec_key;
      open_in = !eoi;
   end

   // result of the group closed by a key change
   always_comb begin
      prev_rsp.result_key   = sga_pkg::KEY_BITS'(key_ff);
      prev_rsp.record_count = count_ff;
      prev_rsp.value_sum    = sum_ff;
      prev_rsp.value_min    = min_old & width_mask;
      prev_rsp.value_max    = max_old & width_mask;
      prev_rsp.final_group  = 1'b0;
   end

   // result of the group closed by end of input
   always_comb begin
      final_rsp.result_key   = sga_pkg::KEY_BITS'(rec_key);
      final_rsp.record_count = count_in;
      final_rsp.value_sum    = sum_in;
      final_rsp.value_min    = sga_pkg::VALUE_BITS'(min_in) & width_mask;
      final_rsp.value_max    = sga_pkg::VALUE_BITS'(max_in) & width_mask;
      final_rsp.final_group  = 1'b1;
   end

   // push control toward the result queue
   assign item_take            = item_valid && room;
   assign push_ctl.push_first  = item_take && (emit_prev || eoi);
   assign push_ctl.push_second = item_take && emit_prev && eoi;
   assign rsp_first            = emit_prev ? prev_rsp : final_rsp;
   assign rsp_second           = final_rsp;

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
      end else if (item_take) begin
         open_ff <= open_in;
      end
   end

   // running totals
   always_ff @(posedge clock) begin
      if (item_take) begin
         key_ff   <= key_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/sga_rsp_fifo.sv */
// ----------------------------------------------------------------------------
// sga_rsp_fifo
// Small result queue. Takes up to two results per cycle in order and hands
// them out one per transfer; reports room for a two-result push.
// ----------------------------------------------------------------------------
`default_nettype none

module sga_rsp_fifo (
   input  wire                   clock,
   input  wire                   reset,
   input  sga_pkg::push_ctl_type push_ctl,
   input  sga_pkg::rsp_type      rsp_first,
   input  sga_pkg::rsp_type      rsp_second,
   output logic                  room,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output sga_pkg::rsp_type      rsp_data
);

   sga_pkg::rsp_type                 entry_ff [sga_pkg::RSP_DEPTH];
   logic [sga_pkg::RSP_PTR_BITS-1:0] wr_ptr_ff;
   logic [sga_pkg::RSP_PTR_BITS-1:0] wr_ptr_in;
   logic [sga_pkg::RSP_PTR_BITS-1:0] wr_next;
   logic [sga_pkg::RSP_PTR_BITS-1:0] rd_ptr_ff;
   logic [sga_pkg::RSP_PTR_BITS-1:0] rd_ptr_in;
   logic [sga_pkg::RSP_CNT_BITS-1:0] count_ff;
   logic [sga_pkg::RSP_CNT_BITS-1:0] count_in;
   logic [sga_pkg::RSP_CNT_BITS-1:0] push_num;
   logic                             pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;

   // room for two entries after this cycle's transfer
   assign room = (count_ff <= sga_pkg::RSP_CNT_BITS'(sga_pkg::RSP_DEPTH - 2)) ||
                 ((count_ff == sga_pkg::RSP_CNT_BITS'(sga_pkg::RSP_DEPTH - 1)) && pop);

   // pointer and fill count update
   always_comb begin
      push_num  = sga_pkg::RSP_CNT_BITS'(push_ctl.push_first) +
                  sga_pkg::RSP_CNT_BITS'(push_ctl.push_second);
      wr_next   = wr_ptr_ff + sga_pkg::RSP_PTR_BITS'(1);
      wr_ptr_in = wr_ptr_ff + push_num[sga_pkg::RSP_PTR_BITS-1:0];
      rd_ptr_in = pop ? rd_ptr_ff + sga_pkg::RSP_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + push_num - sga_pkg::RSP_CNT_BITS'(pop);
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push_ctl.push_first) begin
         entry_ff[wr_ptr_ff] <= rsp_first;
      end
      if (push_ctl.push_second) begin
         entry_ff[wr_next] <= rsp_second;
      end
   end

endmodule

`default_nettype wire

/* bench/sorted_group_aggregator_tb.sv */
// ----------------------------------------------------------------------------
// sorted_group_aggregator_tb
// Self-checking bench for the sorted group aggregator. A directed table goes
// first: stream extremes, key changes, the end-of-input close, signed and
// unsigned columns, out-of-range widths and a width change inside an open
// group. Random streams of key runs follow under a series of width and
// signedness settings. Every result transfer is checked field by field
// against a group predictor that runs beside the block, with random idle
// bursts on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_group_aggregator_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_ROWS       = 22;
   localparam int NUM_PHASES     = 12;
   localparam int RECS_PER_PHASE = 100;
   localparam int SETTLE_CYCLES  = 4;
   localparam int QUIET_LIMIT    = 2000;
   localparam int SHOW_LIMIT     = 10;

   typedef enum logic [0:0] {ROW_REC, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type                       kind;
      logic [sga_pkg::KEY_BITS-1:0]       group_key;
      logic [sga_pkg::VALUE_BITS-1:0]     value;
      logic                               eoi;
      logic [sga_pkg::CSR_INDEX_BITS-1:0] csr_idx;
      logic [sga_pkg::CSR_DATA_BITS-1:0]  csr_val;
      logic                               has_lit;
      sga_pkg::rsp_type                   lit;
   } plan_row_type;

   typedef struct {
      logic             on;
      sga_pkg::rsp_type grp;
   } lit_note_type;

   // block ports
   logic                               clock        = 1'b0;
   logic                               reset        = 1'b1;
   logic                               req_valid    = 1'b0;
   logic                               req_ready;
   sga_pkg::req_type                   req_data     = '0;
   logic                               rsp_valid;
   logic                               rsp_ready    = 1'b0;
   sga_pkg::rsp_type                   rsp_data;
   logic                               csr_write_en = 1'b0;
   logic [sga_pkg::CSR_INDEX_BITS-1:0] csr_index    = '0;
   logic [sga_pkg::CSR_DATA_BITS-1:0]  csr_wdata    = '0;

   // predictor state and register copies
   logic                           cfg_signed = 1'b0;
   logic [sga_pkg::BYTES_BITS-1:0] cfg_bytes  = sga_pkg::RESET_VALUE_BYTES;
   logic                           grp_open   = 1'b0;
   logic [sga_pkg::KEY_BITS-1:0]   grp_key    = '0;
   logic [sga_pkg::COUNT_BITS-1:0] grp_count  = '0;
   logic [sga_pkg::VALUE_BITS-1:0] grp_sum    = '0;
   logic [sga_pkg::VALUE_BITS-1:0] grp_min    = 64'hFFFF_FFFF;
   logic [sga_pkg::VALUE_BITS-1:0] grp_max    = '0;

   sga_pkg::rsp_type pending_groups[$];
   lit_note_type     lit_notes[$];

   int fail_count = 0;
   int shown      = 0;
   int stall_odds = 4;
   int quiet      = 0;

   // directed stimulus, literal results only where obvious
   plan_row_type directed_plan [NUM_ROWS] = '{
      // single record closed at once, reset width of 4 unsigned bytes
      '{ROW_REC, 64'h0, '1, 1'b1, '0, '0, 1'b1,
        '{64'h0, 32'd1, 64'hFFFF_FFFF, 64'hFFFF_FFFF, 64'hFFFF_FFFF, 1'b1}},
      '{ROW_REC, '1, 64'h0, 1'b1, '0, '0, 1'b1,
        '{'1, 32'd1, 64'h0, 64'h0, 64'h0, 1'b1}},
      // key change closes the previous group
      '{ROW_REC, 64'h1, 64'h5, 1'b0, '0, '0, 1'b0, '0},
      '{ROW_REC, 64'h1, 64'h3, 1'b0, '0, '0, 1'b0, '0},
      '{ROW_REC, 64'h2, 64'h7, 1'b0, '0, '0, 1'b1,
        '{64'h1, 32'd2, 64'h8, 64'h3, 64'h5, 1'b0}},
      // key change and end of input on one record
      '{ROW_REC, 64'h3, 64'h9, 1'b1, '0, '0, 1'b0, '0},
      // signed single byte column, upper bytes ignored
      '{ROW_CSR, '0, '0, 1'b0, sga_pkg::CSR_VALUE_SIGNED, 4'd1, 1'b0, '0},
      '{ROW_CSR, '0, '0, 1'b0, sga_pkg::CSR_VALUE_BYTES, 4'd1, 1'b0, '0},
      '{ROW_REC, 64'h4, 64'h7F, 1'b0, '0, '0, 1'b0, '0},
      '{ROW_REC, 64'h4, 64'h80, 1'b0, '0, '0, 1'b0, '0},
      '{ROW_REC, 64'h4, 64'hFFFF_FF01, 1'b1, '0, '0, 1'b0, '0},
      // zero width behaves as one byte
      '{ROW_CSR, '0, '0, 1'b0, sga_pkg::CSR_VALUE_BYTES, 4'd0, 1'b0, '0},
      '{ROW_REC, 64'h5, 64'h180, 1'b0, '0, '0, 1'b0, '0},
      '{ROW_REC, 64'h5, 64'h7F, 1'b0, '0, '0, 1'b0, '0},
      // oversized width saturates, and changes while the group is open
      '{ROW_CSR, '0, '0, 1'b0, sga_pkg::CSR_VALUE_BYTES, 4'd15, 1'b0, '0},
      '{ROW_REC, 64'h5, 64'h8000_0000_0000_0000, 1'b1, '0, '0, 1'b0, '0},
      // full width unsigned
      '{ROW_CSR, '0, '0, 1'b0, sga_pkg::CSR_VALUE_SIGNED, 4'd0, 1'b0, '0},
      '{ROW_REC, 64'h6, '1, 1'b0, '0, '0, 1'b0, '0},
      '{ROW_REC, 64'h6, 64'h0, 1'b0, '0, '0, 1'b0, '0},
      '{ROW_REC, 64'h7, 64'h1, 1'b1, '0, '0, 1'b0, '0},
      // back to four bytes, top bit set as unsigned
      '{ROW_CSR, '0, '0, 1'b0, sga_pkg::CSR_VALUE_BYTES, 4'd4, 1'b0, '0},
      '{ROW_REC, '1, 64'h8000_0000, 1'b1, '0, '0, 1'b1,
        '{'1, 32'd1, 64'h8000_0000, 64'h8000_0000, 64'h8000_0000, 1'b1}}
   };

   // fixed settings first, the extremes among them, random ones after
   logic                           phase_signed [8] =
      '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
   logic [sga_pkg::BYTES_BITS-1:0] phase_bytes  [8] =
      '{4'd1, 4'd1, 4'd8, 4'd8, 4'd0, 4'd15, 4'd2, 4'd3};

   sorted_group_aggregator u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // effective column width in bytes
   function automatic int width_of(logic [sga_pkg::BYTES_BITS-1:0] b);
      if (b < 1) return 1;
      if (b > sga_pkg::DEF_MAX_VALUE_BYTES) return sga_pkg::DEF_MAX_VALUE_BYTES;
      return int'(b);
   endfunction

   function automatic logic [63:0] col_mask(int w);
      if (w >= 8) return '1;
      return (64'd1 << (8 * w)) - 64'd1;
   endfunction

   function automatic logic [63:0] col_sign(int w);
      return 64'h80 << (8 * (w - 1));
   endfunction

   // ordering at the current width and signedness
   function automatic logic col_less(logic [63:0] a, logic [63:0] b);
      int          w;
      logic [63:0] m;
      logic [63:0] bias;
      w    = width_of(cfg_bytes);
      m    = col_mask(w);
      bias = cfg_signed ? col_sign(w) : 64'h0;
      return ((a & m) ^ bias) < ((b & m) ^ bias);
   endfunction

   function automatic sga_pkg::rsp_type group_totals(logic fin);
      sga_pkg::rsp_type g;
      logic [63:0]      m;
      m              = col_mask(width_of(cfg_bytes));
      g.result_key   = grp_key;
      g.record_count = grp_count;
      g.value_sum    = grp_sum;
      g.value_min    = grp_min & m;
      g.value_max    = grp_max & m;
      g.final_group  = fin;
      return g;
   endfunction

   // fold one record into the open group, queue the groups it closes
   function automatic void fold_record(sga_pkg::req_type r);
      int          w;
      logic [63:0] m;
      logic [63:0] v;
      logic [63:0] ext;
      w   = width_of(cfg_bytes);
      m   = col_mask(w);
      v   = r.value & m;
      ext = (cfg_signed && (v & col_sign(w)) != 0) ? (v | ~m) : v;
      if (grp_open && r.group_key != grp_key) begin
         pending_groups.push_back(group_totals(1'b0));
         grp_open = 1'b0;
      end
      if (!grp_open) begin
         grp_open  = 1'b1;
         grp_key   = r.group_key;
         grp_count = 32'd1;
         grp_sum   = ext;
         grp_min   = v;
         grp_max   = v;
      end else begin
         grp_count = grp_count + 32'd1;
         grp_sum   = grp_sum + ext;
         if (col_less(v, grp_min)) grp_min = v;
         if (col_less(grp_max, v)) grp_max = v;
      end
      if (r.end_of_input) begin
         pending_groups.push_back(group_totals(1'b1));
         grp_open  = 1'b0;
         grp_key   = '0;
         grp_count = '0;
         grp_sum   = '0;
         grp_min   = cfg_signed ? (m & ~col_sign(w)) : m;
         grp_max   = cfg_signed ? col_sign(w) : 64'h0;
      end
   endfunction

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         fail_count++;
         if (shown < SHOW_LIMIT) begin
            shown++;
            $display("mismatch %s: expected %h, got %h", name, want, got);
         end
      end
   endfunction

   // result checking and prediction, sampled at the clock edge
   always @(posedge clock) begin
      sga_pkg::rsp_type want;
      lit_note_type     note;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_groups.size() == 0) begin
               fail_count++;
               if (shown < SHOW_LIMIT) begin
                  shown++;
                  $display("unexpected result transfer, key %h", rsp_data.result_key);
               end
            end else begin
               want = pending_groups.pop_front();
               check_field("result_key", want.result_key, rsp_data.result_key);
               check_field("record_count", 64'(want.record_count),
                           64'(rsp_data.record_count));
               check_field("value_sum", want.value_sum, rsp_data.value_sum);
               check_field("value_min", want.value_min, rsp_data.value_min);
               check_field("value_max", want.value_max, rsp_data.value_max);
               check_field("final_group", 64'(want.final_group),
                           64'(rsp_data.final_group));
            end
         end
         if (csr_write_en) begin
            if (csr_index == sga_pkg::CSR_VALUE_SIGNED) begin
               cfg_signed = csr_wdata[0];
            end else if (csr_index == sga_pkg::CSR_VALUE_BYTES) begin
               cfg_bytes = csr_wdata[sga_pkg::BYTES_BITS-1:0];
            end
         end
         if (req_valid && req_ready) begin
            note = lit_notes.pop_front();
            fold_record(req_data);
            if (note.on) pending_groups[$] = note.grp;
         end
      end
   end

   // result side back-pressure in bursts
   always @(posedge clock) begin
      int stall_left;
      if (stall_odds == 0) begin
         stall_left = 0;
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(1, stall_odds * 2) == 1) begin
         stall_left = $urandom_range(0, 11);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", quiet);
         $display("Some tests failed");
         $finish;
      end
   end

   // one record transfer, then maybe an idle burst
   task automatic send_record(logic [63:0] key, logic [63:0] val, logic eoi,
                              logic has_lit, sga_pkg::rsp_type lit);
      lit_note_type     note;
      sga_pkg::req_type r;
      note.on        = has_lit;
      note.grp       = lit;
      r.group_key    = key;
      r.value        = val;
      r.end_of_input = eoi;
      lit_notes.push_back(note);
      req_data  <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   // stop sending and wait until every expected group has arrived
   task automatic settle(int extra);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_groups.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_csr(logic [sga_pkg::CSR_INDEX_BITS-1:0] idx,
                            logic [sga_pkg::CSR_DATA_BITS-1:0] val);
      csr_index    <= idx;
      csr_wdata    <= val;
      csr_write_en <= 1'b1;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // value, often fully random, else a special pattern at the column width with junk above it
   function automatic logic [63:0] pick_value(int w);
      logic [63:0] m;
      logic [63:0] junk;
      m    = col_mask(w);
      junk = rand64() & ~m;
      case ($urandom_range(0, 9))
         0:       return junk;
         1:       return junk | m;
         2:       return junk | col_sign(w);
         3:       return junk | (m & ~col_sign(w));
         default: return rand64();
      endcase
   endfunction

   initial begin
      logic [63:0]                    run_key;
      logic                           p_signed;
      logic [sga_pkg::BYTES_BITS-1:0] p_bytes;
      int                             left;
      int                             glen;
      int                             w;
      logic                           eoi;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == ROW_CSR) begin
            settle(SETTLE_CYCLES);
            write_csr(directed_plan[i].csr_idx, directed_plan[i].csr_val);
         end else begin
            send_record(directed_plan[i].group_key, directed_plan[i].value,
                        directed_plan[i].eoi, directed_plan[i].has_lit,
                        directed_plan[i].lit);
         end
      end

      // random streams of key runs, one setting per phase
      run_key = rand64();
      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p < 8) begin
            p_signed = phase_signed[p];
            p_bytes  = phase_bytes[p];
         end else begin
            p_signed = 1'($urandom_range(0, 1));
            p_bytes  = sga_pkg::BYTES_BITS'($urandom_range(0, 15));
         end
         settle(SETTLE_CYCLES);
         write_csr(sga_pkg::CSR_VALUE_SIGNED, sga_pkg::CSR_DATA_BITS'(p_signed));
         write_csr(sga_pkg::CSR_VALUE_BYTES, p_bytes);
         if (p == NUM_PHASES - 1) stall_odds = 0;
         else case ($urandom_range(0, 2))
            0:       stall_odds = 0;
            1:       stall_odds = 3;
            default: stall_odds = 8;
         endcase
         w    = width_of(p_bytes);
         left = RECS_PER_PHASE;
         while (left > 0) begin
            // next group: usually a larger key, sometimes a jump or the same key
            if ($urandom_range(0, 7) == 0) run_key = rand64();
            else if ($urandom_range(0, 5) != 0) run_key = run_key + $urandom_range(1, 1000);
            glen = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
            for (int i = 0; i < glen && left > 0; i++) begin
               eoi = (i == glen - 1 && $urandom_range(0, 5) == 0) ||
                     $urandom_range(0, 39) == 0;
               send_record(run_key, pick_value(w), eoi, 1'b0, '0);
               left--;
            end
         end
      end

      // close the last open group
      send_record(run_key, rand64(), 1'b1, 1'b0, '0);
      settle(10);
      if (pending_groups.size() != 0) begin
         fail_count++;
         $display("%0d expected groups never arrived", pending_groups.size());
      end
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
